/* rtl/mdtt_pkg.sv */
`default_nettype none
package mdtt_pkg;

    localparam int unsigned TableDepthDef = 16;
    localparam int unsigned MaxResults    = 16;

    // operation codes
    localparam logic [2:0] ModeSeen   = 3'd0;
    localparam logic [2:0] ModePos    = 3'd1;
    localparam logic [2:0] ModeLimits = 3'd2;
    localparam logic [2:0] ModeMove   = 3'd3;
    localparam logic [2:0] ModeSweep  = 3'd4;
    localparam logic [2:0] ModeRemove = 3'd5;

    // register indexes
    localparam logic RegTimeout = 1'b0;
    localparam logic RegStall   = 1'b1;

    localparam logic [15:0] LimitUnset = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  mode;
        logic [23:0] addr;
        logic [1:0]  source;
        logic [31:0] time_ms;
        logic        report_fault;
        logic        report_valid;
        logic [15:0] pulses;
        logic [7:0]  percent;
        logic [15:0] up_limit;
        logic [15:0] down_limit;
        logic [1:0]  move_dir;
        logic [7:0]  goal_pct;
    } t_in;

    typedef struct packed {
        logic        found;
        logic [3:0]  slot;
        logic        table_full;
        logic        now_online;
        logic        changed;
        logic        fault_set;
        logic        fault_clr;
        logic        move_done;
        logic        stalled;
        logic [7:0]  cur_pct;
        logic [23:0] offline_addr;
        logic        last;
    } t_out;

    // one table entry as stored in memory (valid bit kept separately)
    typedef struct packed {
        logic [23:0] addr;
        logic [1:0]  source;
        logic [31:0] last_seen;
        logic        online;
        logic        pos_known;
        logic [7:0]  pct;
        logic [15:0] pulses;
        logic [1:0]  motion;
        logic [7:0]  target;
        logic [7:0]  stalls;
        logic        fault;
        logic [15:0] up_limit;
        logic [15:0] down_limit;
        logic        lim_known;
    } t_entry;

endpackage
`default_nettype wire

/* rtl/motor_device_table_tracker.sv */
// Motor table of TABLE_DEPTH entries held in one synchronous memory with
// per-entry valid flip-flops (an invalid entry reads as all zero). Each
// lookup or sweep item scans the table one entry per cycle through the
// memory read port; a sweep pauses its scan while a held result is sent.
// A lookup item passes from the accept through the search, a read, a
// modify step and a state that holds the result until it is taken; for
// an unknown address or a full table the result is loaded at the read
// and the modify step is skipped. A sweep sends each reported entry
// through an output step that waits on any output stall. An unused mode
// loads its result at the accept, with no scan. Input stall is high
// whenever an item is in progress. Configure only while idle.
`default_nettype none
module motor_device_table_tracker #(
    parameter int unsigned TABLE_DEPTH = mdtt_pkg::TableDepthDef
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  mdtt_pkg::t_in       i_data,
    output logic                o_valid,
    input  wire                 i_stall,
    output mdtt_pkg::t_out      o_data,
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_index,
    input  wire [31:0]          i_cfg_data
);
    import mdtt_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned NW = $clog2(MaxResults + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;
    localparam logic [2:0] S_SWEEP = 3'd5;
    localparam logic [2:0] S_SWOUT = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    t_entry r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_used;

    logic [2:0]    r_state;
    t_in           r_in;
    logic [31:0]   r_timeout;
    logic [7:0]    r_stall_lim;
    logic [CW-1:0] r_cnt;     // address issued to memory
    logic          r_rv;      // read data valid for r_ridx
    logic [AW-1:0] r_ridx;
    t_entry        r_rd;
    logic          r_hit, r_free_ok;
    logic [AW-1:0] r_hit_idx, r_free_idx;
    logic [NW-1:0] r_nres;
    logic          r_pend;    // sweep result waiting in r_swres
    t_out          r_swres;
    logic          r_sw_any;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    t_entry        mem_wd;
    logic [AW-1:0] rd_addr;
    t_entry        ent;
    logic          ent_used;

    // memory: registered read, one write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[rd_addr];
    end

    assign ent_used = r_used[r_ridx];
    always_comb begin
        ent = ent_used ? r_rd : '0;
    end

    assign o_stall = (r_state != S_IDLE);

    // sweep timeout test on the entry just read
    logic        sw_out;
    logic        sw_cap;    // timed-out entry that still gets a result
    logic        sw_hold;   // send the held result before taking this entry
    logic [31:0] age;
    assign age     = r_in.time_ms - ent.last_seen;
    assign sw_out  = r_rv && ent_used && ent.online && (age >= r_timeout);
    assign sw_cap  = sw_out && (r_nres < NW'(MaxResults));
    assign sw_hold = r_pend && sw_cap;

    // position update
    t_entry pe;
    t_out   po;
    logic   first, spur, moving;
    always_comb begin
        pe = ent;
        po = '0;
        first = 1'b0; spur = 1'b0; moving = 1'b0;
        pe.last_seen = r_in.time_ms;
        if (r_in.report_fault || !r_in.report_valid) begin
            pe.motion = 2'd0;
            pe.stalls = 8'd0;
            if (!ent.fault) begin
                pe.fault = 1'b1;
                po.fault_set = 1'b1;
                po.changed = 1'b1;
            end
        end else begin
            if (ent.fault) begin
                pe.fault = 1'b0;
                po.fault_clr = 1'b1;
                po.changed = 1'b1;
            end
            first = !ent.pos_known;
            pe.pos_known = 1'b1;
            pe.pulses = r_in.pulses;
            spur = !first && ent.motion == 2'd0 && r_in.pulses == ent.pulses
                   && r_in.percent != ent.pct;
            if ((ent.pct != r_in.percent && !spur) || first) begin
                pe.pct = r_in.percent;
                pe.stalls = 8'd0;
                po.changed = 1'b1;
            end
            moving = (ent.motion != 2'd0);
            if (moving && r_in.percent == ent.target) begin
                pe.motion = 2'd0;
                pe.stalls = 8'd0;
                po.move_done = 1'b1;
                po.changed = 1'b1;
                moving = 1'b0;
            end
            if (moving && ent.pct == r_in.percent && !first) begin
                pe.stalls = pe.stalls + 8'd1;
                if (pe.stalls >= r_stall_lim) begin
                    pe.fault = 1'b1;
                    pe.motion = 2'd0;
                    pe.stalls = 8'd0;
                    po.stalled = 1'b1;
                    po.fault_set = 1'b1;
                    po.changed = 1'b1;
                end
            end
        end
    end

    // modify step for lookup modes
    t_entry me;
    t_out   mo;
    logic   m_we, m_set, m_clr;
    logic   any_lim;
    always_comb begin
        me = ent; mo = '0; m_we = 1'b0; m_set = 1'b0; m_clr = 1'b0;
        any_lim = (r_in.up_limit != LimitUnset) || (r_in.down_limit != LimitUnset);
        mo.last = 1'b1;
        mo.found = 1'b1;
        mo.slot = 4'(r_ridx);
        unique case (r_in.mode)
            ModeSeen: begin
                if (!r_hit) begin
                    me = '0;
                    me.addr = r_in.addr;
                    me.source = r_in.source;
                    m_set = 1'b1;
                end else if (r_in.source < ent.source) begin
                    me.source = r_in.source;
                end
                mo.now_online = !me.online;
                me.last_seen = r_in.time_ms;
                me.online = 1'b1;
                m_we = 1'b1;
            end
            ModePos: begin
                me = pe;
                mo = po;
                mo.last = 1'b1;
                mo.found = 1'b1;
                mo.slot = 4'(r_ridx);
                m_we = 1'b1;
            end
            ModeLimits: begin
                if (r_in.report_valid) begin
                    mo.changed = (ent.lim_known != any_lim) ||
                                 (ent.up_limit != r_in.up_limit) ||
                                 (ent.down_limit != r_in.down_limit);
                    me.up_limit = r_in.up_limit;
                    me.down_limit = r_in.down_limit;
                    me.lim_known = any_lim;
                    m_we = 1'b1;
                end
            end
            ModeMove: begin
                me.motion = r_in.move_dir;
                me.target = r_in.goal_pct;
                me.stalls = 8'd0;
                m_we = 1'b1;
            end
            ModeRemove: begin
                me = '0;
                m_clr = 1'b1;
            end
            default: ;
        endcase
        mo.cur_pct = me.pct;
    end

    // fixed results: unused mode, lookup miss, sweep capture and give
    logic rd_miss;
    t_out bad_res, miss_res, sw_res, sw_give;
    assign rd_miss = !r_hit && (r_in.mode != ModeSeen || !r_free_ok);
    always_comb begin
        bad_res = '0;
        bad_res.last = 1'b1;
        miss_res = bad_res;
        miss_res.table_full = (r_in.mode == ModeSeen);
        sw_res = '0;
        sw_res.found = 1'b1;
        sw_res.slot = 4'(r_ridx);
        sw_res.cur_pct = ent.pct;
        sw_res.offline_addr = ent.addr;
        sw_give = r_swres;
        sw_give.last = r_sw_any;
    end

    // load the output register
    logic out_load;
    assign out_load = ((r_state == S_IDLE) && i_valid && (i_data.mode > ModeRemove)) ||
                      ((r_state == S_RD) && rd_miss) ||
                      (r_state == S_MOD) ||
                      ((r_state == S_SWOUT) && (!o_valid || !i_stall));

    // memory address and write select
    always_comb begin
        rd_addr = AW'(r_cnt);
        mem_we = 1'b0;
        mem_wa = r_ridx;
        mem_wd = me;
        if (r_state == S_RD) begin
            rd_addr = r_hit ? r_hit_idx : r_free_idx;
        end
        // hold the read on the entry whose result waits
        if (r_state == S_SWOUT || (r_state == S_SWEEP && sw_hold)) begin
            rd_addr = r_ridx;
        end
        if (r_state == S_MOD) begin
            mem_we = m_we;
        end else if (r_state == S_SWEEP && sw_out && !sw_hold) begin
            mem_we = 1'b1;
            mem_wd = ent;
            mem_wd.online = 1'b0;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            r_timeout <= 32'd60000;
            r_stall_lim <= 8'd3;
            o_valid <= 1'b0;
            r_rv <= 1'b0;
            r_pend <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    RegTimeout: r_timeout <= i_cfg_data;
                    RegStall:   r_stall_lim <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            o_valid <= out_load || (o_valid && i_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_in <= i_data;
                        r_cnt <= '0;
                        r_rv <= 1'b0;
                        r_hit <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_nres <= '0;
                        r_pend <= 1'b0;
                        r_sw_any <= 1'b0;
                        if (i_data.mode == ModeSweep) begin
                            r_state <= S_SWEEP;
                        end else if (i_data.mode > ModeRemove) begin
                            o_data <= bad_res;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                // search by valid bits and address compare, one slot a cycle
                S_SCAN: begin
                    if (r_cnt < CW'(TABLE_DEPTH)) begin
                        if (!r_used[AW'(r_cnt)] && !r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free_idx <= AW'(r_cnt);
                        end
                    end
                    if (r_rv && ent_used && !r_hit && ent.addr == r_in.addr) begin
                        r_hit <= 1'b1;
                        r_hit_idx <= r_ridx;
                    end
                    r_ridx <= AW'(r_cnt);
                    r_rv <= (r_cnt < CW'(TABLE_DEPTH));
                    if (r_cnt == CW'(TABLE_DEPTH)) begin
                        r_state <= S_RD;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_RD: begin
                    r_ridx <= r_hit ? r_hit_idx : r_free_idx;
                    r_rv <= 1'b0;
                    if (rd_miss) begin
                        o_data <= miss_res;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (m_set) r_used[r_ridx] <= 1'b1;
                    if (m_clr) r_used[r_ridx] <= 1'b0;
                    o_data <= mo;
                    r_state <= S_DONE;
                end
                // sweep: read each slot, write timed-out ones back offline, hold one result
                S_SWEEP: begin
                    if (sw_hold) begin
                        r_state <= S_SWOUT;
                    end else begin
                        if (sw_cap) begin
                            r_pend <= 1'b1;
                            r_nres <= r_nres + NW'(1);
                            r_swres <= sw_res;
                        end
                        r_ridx <= AW'(r_cnt);
                        r_rv <= (r_cnt < CW'(TABLE_DEPTH));
                        if (r_cnt == CW'(TABLE_DEPTH)) begin
                            if (r_pend || sw_cap) begin
                                r_state <= S_SWOUT;
                                r_sw_any <= 1'b1;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                    end
                end
                // give held result; at scan end it is the last one
                S_SWOUT: begin
                    if (!o_valid || !i_stall) begin
                        o_data <= sw_give;
                        r_pend <= 1'b0;
                        r_state <= r_sw_any ? S_DONE : S_SWEEP;
                    end
                end
                S_DONE: begin
                    if (!o_valid || !i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
